/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/bpfa_pkg.sv */
// Package with types and constants of the bitmap page frame allocator.
`timescale 1ns / 1ps
`default_nettype none
package bpfa_pkg;

	localparam int ADDR_W = 24;
	localparam int CNT_W = 13;
	localparam int WORD_BITS = 64;
	localparam logic [CNT_W-1:0] COUNT_MAX = 13'h1FFF;
	localparam logic [CNT_W-1:0] PAGE_LIMIT_RESET = 13'd4096;

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE = 2'd1;
	localparam logic [1:0] OP_RESERVE = 2'd2;
	localparam logic [1:0] OP_MARK_ALL = 2'd3;

	localparam logic [1:0] STATUS_DONE = 2'd0;
	localparam logic [1:0] STATUS_OOM = 2'd1;
	localparam logic [1:0] STATUS_IGNORED = 2'd2;

	localparam logic REG_PAGE_LIMIT = 1'b0;

	typedef struct packed {
		logic [1:0] operation;
		logic [ADDR_W-1:0] address;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] page_address;
		logic [1:0] status;
		logic [CNT_W-1:0] free_count;
	} rsp_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_SCAN,
		S_READ,
		S_MODIFY,
		S_CLEAR,
		S_PUSH
	} state_t;

	typedef struct packed {
		logic accept;
		logic clr_step;
		logic clear_done;
		logic scan_step;
		logic read_page;
		logic modify;
		logic push;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] req_op;
		logic clr_last;
		logic scan_hit;
		logic scan_oom;
		logic rsp_free;
	} dp_stat_t;

endpackage
`default_nettype wire

/* hw/rtl/bpfa_ctrl.sv */
// Controller state machine of the bitmap page frame allocator.
`timescale 1ns / 1ps
`default_nettype none
module bpfa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  bpfa_pkg::dp_stat_t stat,
	output bpfa_pkg::dp_cmd_t  cmd
);
	import bpfa_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_INIT: begin
				if (stat.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) begin
					unique case (stat.req_op)
						OP_ALLOC: state_d = S_SCAN;
						OP_FREE: state_d = S_READ;
						OP_RESERVE: state_d = S_READ;
						OP_MARK_ALL: state_d = S_CLEAR;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_SCAN: begin
				if (stat.scan_hit || stat.scan_oom) state_d = S_PUSH;
			end
			S_READ: state_d = S_MODIFY;
			S_MODIFY: state_d = S_PUSH;
			S_CLEAR: begin
				if (stat.clr_last) state_d = S_PUSH;
			end
			S_PUSH: begin
				if (stat.rsp_free) state_d = S_IDLE;
			end
			default: state_d = S_INIT;
		endcase
	end

	always_comb begin
		cmd = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_INIT: cmd.clr_step = 1'b1;
			S_IDLE: begin
				req_ready = 1'b1;
				cmd.accept = req_valid;
			end
			S_SCAN: cmd.scan_step = 1'b1;
			S_READ: cmd.read_page = 1'b1;
			S_MODIFY: cmd.modify = 1'b1;
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				cmd.clear_done = stat.clr_last;
			end
			S_PUSH: cmd.push = stat.rsp_free;
			default: cmd = '0;
		endcase
	end

endmodule
`default_nettype wire

/* hw/rtl/bpfa_dp.sv */
// Datapath of the bitmap page frame allocator: bitmap memory, scan, count and result.
`timescale 1ns / 1ps
`default_nettype none
module bpfa_dp #(
	parameter int MAX_PAGES = 4096,
	parameter int PAGE_SHIFT = 12
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bpfa_pkg::req_t                 req_data,
	input  logic [bpfa_pkg::CNT_W-1:0]     page_limit,
	input  bpfa_pkg::dp_cmd_t              cmd,
	output bpfa_pkg::dp_stat_t             stat,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output bpfa_pkg::rsp_t                 rsp_data
);
	import bpfa_pkg::*;

	localparam int WORD_COUNT = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int WIDX_W = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int LIM_W = $clog2(MAX_PAGES + 1);
	localparam int PG_W = ADDR_W - PAGE_SHIFT;

	logic [WORD_BITS-1:0] mem [WORD_COUNT];
	logic [WORD_BITS-1:0] rd_data_q;

	logic [1:0] op_q;
	logic [PG_W-1:0] page_q;
	logic [WIDX_W-1:0] clr_idx_q;
	logic [WIDX_W:0] scan_idx_q;
	logic [WIDX_W-1:0] chk_idx_q;
	logic pend_q;
	logic [CNT_W-1:0] count_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic [1:0] res_status_q;
	logic rsp_valid_q;
	rsp_t rsp_data_q;

	logic [LIM_W-1:0] eff_lim;
	logic [WIDX_W+6:0] scan_base;
	logic [WIDX_W+5:0] chk_base;
	logic issue;
	logic [LIM_W-1:0] rem;
	logic [WORD_BITS-1:0] lim_mask;
	logic [WORD_BITS-1:0] free_bits;
	logic [WORD_BITS-1:0] lowest;
	logic [5:0] hit_bit;
	logic [WIDX_W+5:0] hit_page;
	logic [63:0] hit_addr;
	logic scan_hit;
	logic scan_oom;
	logic [31:0] page32;
	logic [WIDX_W-1:0] page_word;
	logic [5:0] page_bit;
	logic page_in_store;
	logic page_in_lim;
	logic page_used;
	logic free_ok;
	logic rsv_ok;
	logic wr_en;
	logic [WIDX_W-1:0] wr_idx;
	logic [WORD_BITS-1:0] wr_data;
	logic rd_en;
	logic [WIDX_W-1:0] rd_idx;

	// A limit above the storage acts as the storage size.
	assign eff_lim = (32'(page_limit) > 32'(MAX_PAGES)) ? LIM_W'(MAX_PAGES)
		: LIM_W'(page_limit);

	// Scan: the word at scan_idx_q is read while the word at chk_idx_q is checked.
	assign scan_base = {scan_idx_q, 6'b0};
	assign issue = 32'(scan_base) < 32'(eff_lim);
	assign chk_base = {chk_idx_q, 6'b0};
	assign rem = LIM_W'(32'(eff_lim) - 32'(chk_base));
	assign lim_mask = (32'(rem) >= 32'(WORD_BITS)) ? '1
		: ((64'd1 << rem[5:0]) - 64'd1);
	assign free_bits = ~rd_data_q & lim_mask;
	assign lowest = free_bits & (~free_bits + 64'd1);

	always_comb begin
		hit_bit = '0;
		for (int j = 0; j < WORD_BITS; j++) begin
			if (lowest[j]) hit_bit = hit_bit | 6'(j);
		end
	end

	assign scan_hit = pend_q && (free_bits != '0);
	assign scan_oom = !pend_q && !issue;
	assign hit_page = {chk_idx_q, hit_bit};
	assign hit_addr = 64'(hit_page) << PAGE_SHIFT;

	assign page32 = 32'(page_q);
	assign page_word = page32[6 +: WIDX_W];
	assign page_bit = page32[5:0];
	assign page_in_store = page32 < 32'(MAX_PAGES);
	assign page_in_lim = page32 < 32'(eff_lim);
	assign page_used = rd_data_q[page_bit];
	assign free_ok = (op_q == OP_FREE) && page_in_lim && page_used;
	assign rsv_ok = (op_q == OP_RESERVE) && page_in_store && !page_used;

	always_comb begin
		wr_en = 1'b0;
		wr_idx = clr_idx_q;
		wr_data = '1;
		priority if (cmd.clr_step) begin
			wr_en = 1'b1;
		end else if (cmd.scan_step && scan_hit) begin
			wr_en = 1'b1;
			wr_idx = chk_idx_q;
			wr_data = rd_data_q | lowest;
		end else if (cmd.modify && (free_ok || rsv_ok)) begin
			wr_en = 1'b1;
			wr_idx = page_word;
			wr_data = free_ok ? (rd_data_q & ~(64'd1 << page_bit))
				: (rd_data_q | (64'd1 << page_bit));
		end
	end

	assign rd_en = (cmd.scan_step && issue) || (cmd.read_page && page_in_store);
	assign rd_idx = cmd.scan_step ? scan_idx_q[WIDX_W-1:0] : page_word;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_idx] <= wr_data;
		if (rd_en) rd_data_q <= mem[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
			scan_idx_q <= '0;
			pend_q <= 1'b0;
			count_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				clr_idx_q <= '0;
			end else if (cmd.clr_step) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end

			if (cmd.accept) begin
				scan_idx_q <= '0;
				pend_q <= 1'b0;
			end else if (cmd.scan_step) begin
				if (issue) scan_idx_q <= scan_idx_q + 1'b1;
				pend_q <= issue;
			end

			priority if (cmd.clear_done) begin
				count_q <= '0;
			end else if ((cmd.scan_step && scan_hit) || (cmd.modify && rsv_ok)) begin
				if (count_q != '0) count_q <= count_q - 1'b1;
			end else if (cmd.modify && free_ok) begin
				if (count_q != COUNT_MAX) count_q <= count_q + 1'b1;
			end

			if (cmd.push) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q <= req_data.operation;
			page_q <= PG_W'(req_data.address >> PAGE_SHIFT);
		end
		if (cmd.scan_step) chk_idx_q <= scan_idx_q[WIDX_W-1:0];

		if (cmd.scan_step && scan_hit) begin
			res_addr_q <= hit_addr[ADDR_W-1:0];
			res_status_q <= STATUS_DONE;
		end else if (cmd.scan_step && scan_oom) begin
			res_addr_q <= '0;
			res_status_q <= STATUS_OOM;
		end else if (cmd.modify) begin
			res_addr_q <= '0;
			res_status_q <= (free_ok || rsv_ok) ? STATUS_DONE : STATUS_IGNORED;
		end else if (cmd.clear_done) begin
			res_addr_q <= '0;
			res_status_q <= STATUS_DONE;
		end

		if (cmd.push) begin
			rsp_data_q.page_address <= res_addr_q;
			rsp_data_q.status <= res_status_q;
			rsp_data_q.free_count <= count_q;
		end
	end

	assign stat.req_op = req_data.operation;
	assign stat.clr_last = clr_idx_q == WIDX_W'(WORD_COUNT - 1);
	assign stat.scan_hit = scan_hit;
	assign stat.scan_oom = scan_oom;
	assign stat.rsp_free = !rsp_valid_q || rsp_ready;

	assign rsp_valid = rsp_valid_q;
	assign rsp_data = rsp_data_q;

endmodule
`default_nettype wire

/* hw/rtl/bitmap_page_frame_allocator_top.sv */
// Top level of the bitmap page frame allocator with its register port.
// Allocate: one bitmap word is read from the bitmap memory per cycle while the scan runs.
// Free and reserve: states S_READ, S_MODIFY and S_PUSH.
// Mark all: one word written per cycle.
// One request is in work at a time; a finished result waits in an output register.
// After reset a clearing pass sets every page used before the first request is taken;
// the free count resets to zero and page_limit to 4096.
`timescale 1ns / 1ps
`default_nettype none
module bitmap_page_frame_allocator_top #(
	parameter int MAX_PAGES = 4096,
	parameter int PAGE_SHIFT = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                req_valid,
	output logic                req_ready,
	input  bpfa_pkg::req_t      req_data,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output bpfa_pkg::rsp_t      rsp_data
);
	import bpfa_pkg::*;

	logic [CNT_W-1:0] page_limit_q;
	dp_cmd_t cmd;
	dp_stat_t stat;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_limit_q <= PAGE_LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_PAGE_LIMIT)) begin
			page_limit_q <= pwdata[CNT_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_PAGE_LIMIT) ? 32'(page_limit_q) : 32'd0;

	bpfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bpfa_dp #(
		.MAX_PAGES  (MAX_PAGES),
		.PAGE_SHIFT (PAGE_SHIFT)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_data   (req_data),
		.page_limit (page_limit_q),
		.cmd        (cmd),
		.stat       (stat),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp_data   (rsp_data)
	);

endmodule
`default_nettype wire

/* hw/rtl/bpfa_checker.sv */
// Port-level checker of the bitmap page frame allocator and its bind statement.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bpfa_checker #(
	parameter int MAX_PAGES = 4096
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_ready,
	input  logic           rsp_valid,
	input  logic           rsp_ready,
	input  bpfa_pkg::rsp_t rsp_data
);
	import bpfa_pkg::*;

	logic rsp_stall;
	logic req_take;
	logic addr_ok;
	logic count_ok;

	assign rsp_stall = rsp_valid && !rsp_ready;
	assign req_take = req_valid && req_ready;
	assign addr_ok = (rsp_data.status == STATUS_DONE) || (rsp_data.page_address == '0);
	assign count_ok = 32'(rsp_data.free_count) <= 32'(MAX_PAGES);

	// A stalled result must hold still.
	`ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_data), "stalled result changed")

	// Every request moves the controller out of idle, so ready drops right after a request.
	`ASSERT_NEXT(a_one_in_work, req_take, !req_ready, "second request taken too early")

	// Only a successful allocate carries a page address.
	`ASSERT_ALWAYS(a_addr_zero, !rsp_valid || addr_ok, "nonzero address without success")

	// The count tracks free pages and never exceeds the storage.
	`ASSERT_ALWAYS(a_count_bound, !rsp_valid || count_ok, "free count above page storage")

endmodule

bind bitmap_page_frame_allocator_top bpfa_checker #(.MAX_PAGES(MAX_PAGES)) u_bpfa_checker (.*);
`default_nettype wire
